FILE: sv/asn1_time_string_parser_defines.svh
// assertion macros for the asn1 time string parser checker
// expects clock and reset in the scope of each use
`ifndef ASN1_TIME_STRING_PARSER_DEFINES_SVH
`define ASN1_TIME_STRING_PARSER_DEFINES_SVH

// same-cycle implication
`define ASN1TP_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASN1TP_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/asn1tp_pkg.sv
// shared types, constants and helpers of the asn1 time string parser
// no dependencies
`default_nettype none

package asn1tp_pkg;

   localparam int MAX_STRING_LEN = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ZULU  = 8'h5A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   localparam logic [12:0] DAY_MINUTES = 13'd1440;
   localparam logic [13:0] YEAR_MIN    = 14'd1900;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;

   typedef enum logic [3:0] {
      PH_YEAR_A, PH_YEAR_B, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
      PH_AFTERSEC, PH_FRAC1, PH_FRACN, PH_ZONE_H, PH_ZONE_M, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      B_IDLE, B_WRAP, B_SPLIT, B_DATE, B_OUT
   } back_state_type;

   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        zone_neg;
      logic [9:0]  zone_mag;
      logic        leap;
   } time_rec_type;

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      unique case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: sv/asn1_time_string_parser.sv
// Parses ASN.1 UTCTime and GeneralizedTime strings arriving one character per request
// and returns one response per string with the date and time after the zone offset.
// A character is taken every cycle while req_stall is low; req_stall rises only while
// the two-entry record queue is full. The date adjuster takes each string through
// dequeue, offset wrap, hour split by reciprocal multiply, date roll and response hold,
// in that order, and dequeues the next record only once the response has been taken,
// so strings can wait in the queue while it works. Invalid strings return time_valid
// low with all fields zero.
// depends on asn1tp_pkg, asn1tp_front, asn1tp_queue, asn1tp_back
`default_nettype none

module asn1_time_string_parser import asn1tp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_first_of_string,
   input  wire logic        req_last_of_string,
   input  wire logic        req_generalized_format,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_time_valid,
   output logic [13:0]      rsp_full_year,
   output logic [3:0]       rsp_month_number,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hour_value,
   output logic [5:0]       rsp_minute_value,
   output logic [5:0]       rsp_second_value
);

   logic         accept, push, pop, full, empty;
   time_rec_type push_rec, pop_rec;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   asn1tp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .text_byte          (req_text_byte),
      .first_of_string    (req_first_of_string),
      .last_of_string     (req_last_of_string),
      .generalized_format (req_generalized_format),
      .push               (push),
      .push_rec           (push_rec)
   );

   asn1tp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .full     (full),
      .empty    (empty)
   );

   asn1tp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_rec          (pop_rec),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_time_valid   (rsp_time_valid),
      .rsp_full_year    (rsp_full_year),
      .rsp_month_number (rsp_month_number),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour_value   (rsp_hour_value),
      .rsp_minute_value (rsp_minute_value),
      .rsp_second_value (rsp_second_value)
   );

endmodule

`default_nettype wire

FILE: sv/asn1tp_front.sv
// character parser: takes one request byte per cycle while accept is high, builds a record per string
// depends on asn1tp_pkg
`default_nettype none

module asn1tp_front import asn1tp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   text_byte,
   input  wire logic         first_of_string,
   input  wire logic         last_of_string,
   input  wire logic         generalized_format,
   output logic              push,
   output time_rec_type      push_rec
);

   phase_type   phase_ff, phase_in;
   logic        high_ff, high_in;
   logic [3:0]  hold_ff, hold_in;
   logic [6:0]  cen_ff, cen_in;
   logic [6:0]  lo_ff, lo_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [10:0] zone_ff, zone_in;
   logic [5:0]  count_ff, count_in;
   logic        err_ff, err_in;
   logic        fmt_ff, fmt_in;

   always_comb begin : next_state
      logic       dig;
      logic       zn;
      logic       go_zone;
      logic [3:0] dg;
      logic [6:0] n;
      phase_in = phase_ff;
      high_in  = high_ff;
      hold_in  = hold_ff;
      cen_in   = cen_ff;
      lo_in    = lo_ff;
      month_in = month_ff;
      day_in   = day_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      zone_in  = zone_ff;
      count_in = count_ff;
      err_in   = err_ff;
      fmt_in   = fmt_ff;
      go_zone  = 1'b0;
      if (first_of_string) begin
         phase_in = PH_YEAR_A;
         high_in  = 1'b0;
         hold_in  = '0;
         cen_in   = '0;
         lo_in    = '0;
         month_in = '0;
         day_in   = '0;
         hour_in  = '0;
         min_in   = '0;
         sec_in   = '0;
         zone_in  = '0;
         count_in = '0;
         err_in   = 1'b0;
         fmt_in   = 1'b0;
      end
      if (count_in == 6'd0) fmt_in = generalized_format;
      if (count_in != 6'd63) count_in = count_in + 6'd1;
      if (count_in > 6'(MAX_STRING_LEN)) err_in = 1'b1;
      dig = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
      zn  = (text_byte == CH_ZULU) || (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
      dg  = text_byte[3:0];
      n   = 7'(hold_in) * 7'd10 + 7'(dg);
      if (!err_in) begin
         if (phase_in == PH_SECOND && !high_in && zn) begin
            go_zone = 1'b1;
         end else if (phase_in == PH_YEAR_A || phase_in == PH_YEAR_B ||
                      phase_in == PH_MONTH || phase_in == PH_DAY ||
                      phase_in == PH_HOUR || phase_in == PH_MINUTE ||
                      phase_in == PH_SECOND || phase_in == PH_ZONE_H ||
                      phase_in == PH_ZONE_M) begin
            if (!dig) begin
               err_in = 1'b1;
            end else if (!high_in) begin
               hold_in = dg;
               high_in = 1'b1;
            end else begin
               high_in = 1'b0;
               unique case (phase_in)
                  PH_YEAR_A: begin
                     if (fmt_in) begin
                        cen_in   = n;
                        phase_in = PH_YEAR_B;
                     end else begin
                        cen_in   = (n < 7'd50) ? 7'd20 : 7'd19;
                        lo_in    = n;
                        phase_in = PH_MONTH;
                     end
                  end
                  PH_YEAR_B: begin
                     lo_in    = n;
                     phase_in = PH_MONTH;
                  end
                  PH_MONTH: begin
                     if (n < 7'd1 || n > 7'd12) err_in = 1'b1;
                     else begin
                        month_in = n[3:0];
                        phase_in = PH_DAY;
                     end
                  end
                  PH_DAY: begin
                     if (n < 7'd1 || n > 7'd31) err_in = 1'b1;
                     else begin
                        day_in   = n[4:0];
                        phase_in = PH_HOUR;
                     end
                  end
                  PH_HOUR: begin
                     if (n > 7'd23) err_in = 1'b1;
                     else begin
                        hour_in  = n[4:0];
                        phase_in = PH_MINUTE;
                     end
                  end
                  PH_MINUTE: begin
                     if (n > 7'd59) err_in = 1'b1;
                     else begin
                        min_in   = n[5:0];
                        phase_in = PH_SECOND;
                     end
                  end
                  PH_SECOND: begin
                     if (n > 7'd59) err_in = 1'b1;
                     else begin
                        sec_in   = n[5:0];
                        phase_in = PH_AFTERSEC;
                     end
                  end
                  PH_ZONE_H: begin
                     if (n > 7'd12) err_in = 1'b1;
                     else begin
                        zone_in[9:0] = zone_in[9:0] + 10'(n) * 10'd60;
                        phase_in     = PH_ZONE_M;
                     end
                  end
                  PH_ZONE_M: begin
                     if (n > 7'd59) err_in = 1'b1;
                     else begin
                        zone_in[9:0] = zone_in[9:0] + 10'(n);
                        phase_in     = PH_DONE;
                     end
                  end
                  default: err_in = 1'b1;
               endcase
            end
         end else if (phase_in == PH_AFTERSEC) begin
            if (text_byte == CH_DOT && fmt_in) phase_in = PH_FRAC1;
            else if (zn) go_zone = 1'b1;
            else err_in = 1'b1;
         end else if (phase_in == PH_FRAC1) begin
            if (dig) phase_in = PH_FRACN;
            else err_in = 1'b1;
         end else if (phase_in == PH_FRACN) begin
            if (!dig) begin
               if (zn) go_zone = 1'b1;
               else err_in = 1'b1;
            end
         end else begin
            err_in = 1'b1;
         end
      end
      if (go_zone) begin
         if (text_byte == CH_ZULU) begin
            phase_in = PH_DONE;
         end else begin
            zone_in  = {(text_byte == CH_MINUS), 10'd0};
            phase_in = PH_ZONE_H;
         end
      end
   end

   always_comb begin : outputs
      push              = accept && last_of_string;
      push_rec.ok       = !err_in &&
                          (phase_in == PH_AFTERSEC || phase_in == PH_FRACN ||
                           phase_in == PH_DONE) &&
                          (count_in >= (fmt_in ? 6'd13 : 6'd11));
      push_rec.year     = 14'(cen_in) * 14'd100 + 14'(lo_in);
      push_rec.month    = month_in;
      push_rec.day      = day_in;
      push_rec.hour     = hour_in;
      push_rec.minute   = min_in;
      push_rec.second   = sec_in;
      push_rec.zone_neg = zone_in[10];
      push_rec.zone_mag = zone_in[9:0];
      push_rec.leap     = (lo_in == 7'd0) ? (cen_in[1:0] == 2'd0) : (lo_in[1:0] == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_of_string)) begin
         phase_ff <= PH_YEAR_A;
         high_ff  <= 1'b0;
         hold_ff  <= '0;
         cen_ff   <= '0;
         lo_ff    <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
         zone_ff  <= '0;
         count_ff <= '0;
         err_ff   <= 1'b0;
         fmt_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         hold_ff  <= hold_in;
         cen_ff   <= cen_in;
         lo_ff    <= lo_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         zone_ff  <= zone_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         fmt_ff   <= fmt_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/asn1tp_queue.sv
// short record queue between the parser and the date adjuster
// depends on asn1tp_pkg
`default_nettype none

module asn1tp_queue import asn1tp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire time_rec_type push_rec,
   input  wire logic         pop,
   output time_rec_type      pop_rec,
   output logic              full,
   output logic              empty
);

   time_rec_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_rec = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

FILE: sv/asn1tp_back.sv
// date adjuster: applies the zone offset, rolls the date by at most one day and drives responses
// depends on asn1tp_pkg
`default_nettype none

module asn1tp_back import asn1tp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         empty,
   input  wire time_rec_type pop_rec,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_time_valid,
   output logic [13:0]       rsp_full_year,
   output logic [3:0]        rsp_month_number,
   output logic [4:0]        rsp_day_of_month,
   output logic [4:0]        rsp_hour_value,
   output logic [5:0]        rsp_minute_value,
   output logic [5:0]        rsp_second_value
);

   back_state_type state_ff, state_in;
   time_rec_type   rec_ff;
   logic [10:0]    t_ff, t_in;
   logic [1:0]     days_ff, days_in;
   logic [4:0]     hq_ff;
   logic [21:0]    prod;
   logic           load_rec, load_wrap, load_split, load_out;

   logic           ov_in, ov_ff;
   logic [13:0]    oy_in, oy_ff;
   logic [3:0]     om_in, om_ff;
   logic [4:0]     od_in, od_ff;
   logic [4:0]     oh_in, oh_ff;
   logic [5:0]     omi_in, omi_ff;
   logic [5:0]     os_in, os_ff;

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!empty) state_in = B_WRAP;
         B_WRAP:  state_in = B_SPLIT;
         B_SPLIT: state_in = B_DATE;
         B_DATE:  state_in = B_OUT;
         B_OUT:   if (!rsp_stall) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin : outputs
      pop        = (state_ff == B_IDLE) && !empty;
      load_rec   = pop;
      load_wrap  = (state_ff == B_WRAP);
      load_split = (state_ff == B_SPLIT);
      load_out   = (state_ff == B_DATE);
      rsp_valid  = (state_ff == B_OUT);
   end

   // minutes of day plus signed offset, wrapped by one day
   always_comb begin : wrap
      logic [12:0] tsum;
      tsum = 13'(rec_ff.hour) * 13'd60 + 13'(rec_ff.minute);
      if (rec_ff.zone_neg) tsum = tsum - 13'(rec_ff.zone_mag);
      else tsum = tsum + 13'(rec_ff.zone_mag);
      days_in = 2'b00;
      if (tsum[12]) begin
         tsum    = tsum + DAY_MINUTES;
         days_in = 2'b11;
      end else if (tsum >= DAY_MINUTES) begin
         tsum    = tsum - DAY_MINUTES;
         days_in = 2'b01;
      end
      t_in = tsum[10:0];
   end

   // floor(t / 60) exact for t below one day
   assign prod = 22'(t_ff) * 22'd1093;

   always_comb begin : date_roll
      logic [6:0]  e;
      logic [4:0]  len;
      logic [13:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
      logic [11:0] mins;
      logic        ok;
      e    = 7'(rec_ff.day) - 7'd1 + {{5{days_ff[1]}}, days_ff};
      len  = month_days(rec_ff.month, rec_ff.leap);
      y    = rec_ff.year;
      m    = rec_ff.month;
      d    = rec_ff.day;
      mins = 12'(t_ff) - 12'(hq_ff) * 12'd60;
      ok   = rec_ff.ok;
      if (rec_ff.zone_mag != 10'd0) begin
         if (e[6]) begin
            if (rec_ff.month == 4'd1) begin
               m = 4'd12;
               y = rec_ff.year - 14'd1;
            end else begin
               m = rec_ff.month - 4'd1;
            end
            d = month_days(m, rec_ff.leap);
         end else if (e[5:0] >= 6'(len)) begin
            d = 5'(e[5:0] - 6'(len) + 6'd1);
            if (rec_ff.month == 4'd12) begin
               m = 4'd1;
               y = rec_ff.year + 14'd1;
            end else begin
               m = rec_ff.month + 4'd1;
            end
         end else begin
            d = 5'(e[5:0] + 6'd1);
         end
         ok = ok && (y >= YEAR_MIN) && (y <= YEAR_MAX);
      end
      ov_in = ok;
      if (ok) begin
         oy_in  = y;
         om_in  = m;
         od_in  = d;
         oh_in  = (rec_ff.zone_mag != 10'd0) ? hq_ff : rec_ff.hour;
         omi_in = (rec_ff.zone_mag != 10'd0) ? mins[5:0] : rec_ff.minute;
         os_in  = rec_ff.second;
      end else begin
         oy_in  = '0;
         om_in  = '0;
         od_in  = '0;
         oh_in  = '0;
         omi_in = '0;
         os_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (load_rec) rec_ff <= pop_rec;
      if (load_wrap) begin
         t_ff    <= t_in;
         days_ff <= days_in;
      end
      if (load_split) hq_ff <= prod[20:16];
      if (load_out) begin
         ov_ff  <= ov_in;
         oy_ff  <= oy_in;
         om_ff  <= om_in;
         od_ff  <= od_in;
         oh_ff  <= oh_in;
         omi_ff <= omi_in;
         os_ff  <= os_in;
      end
   end

   assign rsp_time_valid   = ov_ff;
   assign rsp_full_year    = oy_ff;
   assign rsp_month_number = om_ff;
   assign rsp_day_of_month = od_ff;
   assign rsp_hour_value   = oh_ff;
   assign rsp_minute_value = omi_ff;
   assign rsp_second_value = os_ff;

endmodule

`default_nettype wire

FILE: sv/asn1tp_checker.sv
// port-level checks of the asn1 time string parser, bound to the top level
// depends on asn1_time_string_parser_defines.svh
`default_nettype none
`include "asn1_time_string_parser_defines.svh"

module asn1tp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_text_byte,
   input wire logic        req_first_of_string,
   input wire logic        req_last_of_string,
   input wire logic        req_generalized_format,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_time_valid,
   input wire logic [13:0] rsp_full_year,
   input wire logic [3:0]  rsp_month_number,
   input wire logic [4:0]  rsp_day_of_month,
   input wire logic [4:0]  rsp_hour_value,
   input wire logic [5:0]  rsp_minute_value,
   input wire logic [5:0]  rsp_second_value
);

   logic        fields_zero;
   logic        fields_in_range;
   logic [40:0] rsp_fields;
   logic [10:0] req_fields;

   assign fields_zero = (rsp_full_year == 14'd0) && (rsp_month_number == 4'd0) &&
                        (rsp_day_of_month == 5'd0) && (rsp_hour_value == 5'd0) &&
                        (rsp_minute_value == 6'd0) && (rsp_second_value == 6'd0);

   assign fields_in_range = (rsp_month_number >= 4'd1) && (rsp_month_number <= 4'd12) &&
                            (rsp_day_of_month >= 5'd1) && (rsp_hour_value <= 5'd23) &&
                            (rsp_minute_value <= 6'd59) && (rsp_second_value <= 6'd59) &&
                            (rsp_full_year <= 14'd9999);

   assign rsp_fields = {rsp_time_valid, rsp_full_year, rsp_month_number, rsp_day_of_month,
                        rsp_hour_value, rsp_minute_value, rsp_second_value};

   assign req_fields = {req_text_byte, req_first_of_string, req_last_of_string,
                        req_generalized_format};

   // invalid request gives an all-zero response
   `ASN1TP_HOLDS(a_invalid_zero, rsp_valid && !rsp_time_valid, fields_zero, "invalid response carries nonzero fields")

   // valid response fields in calendar range
   `ASN1TP_HOLDS(a_valid_range, rsp_valid && rsp_time_valid, fields_in_range, "valid response out of range")

   // stalled response holds
   `ASN1TP_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields), "stalled response changed")

   // stalled request holds
   `ASN1TP_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_fields), "stalled request changed")

endmodule

bind asn1_time_string_parser asn1tp_checker u_checker (.*);

`default_nettype wire

FILE: tb/asn1_time_string_parser_checker.sv
// checker for the asn1 time string parser: predicts each response from the accepted
// requests and compares it with the block's response, field by field
// depends on asn1tp_pkg
`timescale 1ns / 100ps
`default_nettype none

module asn1_time_string_parser_checker import asn1tp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_first_of_string,
   input  wire logic        req_last_of_string,
   input  wire logic        req_generalized_format,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_time_valid,
   input  wire logic [13:0] rsp_full_year,
   input  wire logic [3:0]  rsp_month_number,
   input  wire logic [4:0]  rsp_day_of_month,
   input  wire logic [4:0]  rsp_hour_value,
   input  wire logic [5:0]  rsp_minute_value,
   input  wire logic [5:0]  rsp_second_value,
   output int               error_count,
   output int               pending_count
);

   localparam int ZONE_NEG = 1024;
   localparam int ZONE_MAG = 1023;

   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } parsed_time_type;

   parsed_time_type expected_times[$];

   phase_type   phase;
   bit          hi_seen, err_seen, gen_fmt;
   int unsigned held_digit, yr, mo, dy, hr, mn, sc, zone, char_cnt;

   function automatic void clear_parser();
      phase = PH_YEAR_A;
      hi_seen = 0; err_seen = 0; gen_fmt = 0;
      held_digit = 0; yr = 0; mo = 0; dy = 0; hr = 0; mn = 0; sc = 0;
      zone = 0; char_cnt = 0;
   endfunction

   function automatic void open_zone(logic [7:0] c);
      if (c == CH_ZULU) begin
         phase = PH_DONE;
      end else begin
         zone = (c == CH_MINUS) ? ZONE_NEG : 0;
         phase = PH_ZONE_H;
      end
   endfunction

   function automatic void take_pair(int unsigned n);
      int unsigned sgn, mag;
      sgn = zone & ZONE_NEG;
      mag = zone & ZONE_MAG;
      case (phase)
         PH_YEAR_A: begin
            if (gen_fmt) begin
               yr = n * 100; phase = PH_YEAR_B;
            end else begin
               yr = (n < 50) ? 2000 + n : 1900 + n; phase = PH_MONTH;
            end
            return;
         end
         PH_YEAR_B: begin yr = yr + n; phase = PH_MONTH; return; end
         PH_MONTH: if (n >= 1 && n <= 12) begin mo = n; phase = PH_DAY; return; end
         PH_DAY: if (n >= 1 && n <= 31) begin dy = n; phase = PH_HOUR; return; end
         PH_HOUR: if (n <= 23) begin hr = n; phase = PH_MINUTE; return; end
         PH_MINUTE: if (n <= 59) begin mn = n; phase = PH_SECOND; return; end
         PH_SECOND: if (n <= 59) begin sc = n; phase = PH_AFTERSEC; return; end
         PH_ZONE_H: if (n <= 12) begin
            zone = sgn | ((mag + n * 60) & ZONE_MAG); phase = PH_ZONE_M; return;
         end
         PH_ZONE_M: if (n <= 59) begin
            zone = sgn | ((mag + n) & ZONE_MAG); phase = PH_DONE; return;
         end
         default: ;
      endcase
      err_seen = 1;
   endfunction

   function automatic void take_char(logic [7:0] c);
      bit is_digit, is_zone;
      is_digit = (c >= CH_ZERO && c <= CH_NINE);
      is_zone = (c == CH_ZULU || c == CH_PLUS || c == CH_MINUS);
      if (err_seen) return;
      if (phase == PH_SECOND && !hi_seen && is_zone) begin
         open_zone(c);
         return;
      end
      if (phase <= PH_SECOND || phase == PH_ZONE_H || phase == PH_ZONE_M) begin
         if (!is_digit) begin err_seen = 1; return; end
         if (!hi_seen) begin
            held_digit = c - CH_ZERO;
            hi_seen = 1;
         end else begin
            hi_seen = 0;
            take_pair(held_digit * 10 + (c - CH_ZERO));
         end
         return;
      end
      if (phase == PH_AFTERSEC) begin
         if (c == CH_DOT && gen_fmt) phase = PH_FRAC1;
         else if (is_zone) open_zone(c);
         else err_seen = 1;
         return;
      end
      if (phase == PH_FRAC1) begin
         if (is_digit) phase = PH_FRACN;
         else err_seen = 1;
         return;
      end
      if (phase == PH_FRACN) begin
         if (is_digit) return;
         if (is_zone) open_zone(c);
         else err_seen = 1;
         return;
      end
      err_seen = 1;
   endfunction

   function automatic longint day_number(longint y, longint m, longint d);
      longint a;
      a = (m - 14) / 12;
      return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
           - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
   endfunction

   function automatic parsed_time_type finish_string();
      parsed_time_type r;
      bit ok;
      longint yy, mm, dd, hh, mi, ss, off, secs, days, jd, l, n, i, j;
      ok = !err_seen && (phase == PH_AFTERSEC || phase == PH_FRACN || phase == PH_DONE)
           && char_cnt >= (gen_fmt ? 13 : 11);
      yy = yr; mm = mo; dd = dy; hh = hr; mi = mn; ss = sc;
      if (ok && (zone & ZONE_MAG) != 0) begin
         off = longint'(zone & ZONE_MAG) * 60;
         if (zone & ZONE_NEG) off = -off;
         secs = off + hh * 3600 + mi * 60 + ss;
         days = 0;
         if (secs >= 86400) begin days = 1; secs -= 86400; end
         else if (secs < 0) begin days = -1; secs += 86400; end
         jd = day_number(yy, mm, dd) + days;
         if (jd < 0) begin
            ok = 0;
         end else begin
            l = jd + 68569;
            n = (4 * l) / 146097;
            l = l - (146097 * n + 3) / 4;
            i = (4000 * (l + 1)) / 1461001;
            l = l - (1461 * i) / 4 + 31;
            j = (80 * l) / 2447;
            dd = l - (2447 * j) / 80;
            l = j / 11;
            mm = j + 2 - 12 * l;
            yy = 100 * (n - 49) + i + l;
            if (yy < 1900 || yy > 9999) ok = 0;
            hh = secs / 3600;
            mi = (secs / 60) % 60;
            ss = secs % 60;
         end
      end
      r = '0;
      if (ok) begin
         r.ok = 1;
         r.year = yy[13:0]; r.month = mm[3:0]; r.day = dd[4:0];
         r.hour = hh[4:0]; r.minute = mi[5:0]; r.second = ss[5:0];
      end
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   parsed_time_type want;

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_times.delete();
         error_count = 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_times.size() == 0) begin
               $display("%0t unexpected response: expected none actual valid=%0d year=%0d",
                        $time, rsp_time_valid, rsp_full_year);
               error_count++;
            end else begin
               want = expected_times.pop_front();
               check_field("time_valid", want.ok, rsp_time_valid);
               check_field("full_year", want.year, rsp_full_year);
               check_field("month_number", want.month, rsp_month_number);
               check_field("day_of_month", want.day, rsp_day_of_month);
               check_field("hour_value", want.hour, rsp_hour_value);
               check_field("minute_value", want.minute, rsp_minute_value);
               check_field("second_value", want.second, rsp_second_value);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_first_of_string) clear_parser();
            if (char_cnt == 0) gen_fmt = req_generalized_format;
            if (char_cnt < 63) char_cnt++;
            if (char_cnt > MAX_STRING_LEN) err_seen = 1;
            take_char(req_text_byte);
            if (req_last_of_string) begin
               expected_times.push_back(finish_string());
               clear_parser();
            end
         end
         pending_count <= expected_times.size();
      end
   end

endmodule

`default_nettype wire

FILE: tb/tb_asn1_time_string_parser.sv
// testbench top for the asn1 time string parser: directed and random time strings,
// random idling on both channels, watchdog and verdict
// depends on asn1tp_pkg, asn1_time_string_parser and asn1_time_string_parser_checker
`timescale 1ns / 100ps
`default_nettype none

module tb_asn1_time_string_parser import asn1tp_pkg::*;;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_CHARS = 1100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_first_of_string = 1'b0;
   logic        req_last_of_string = 1'b0;
   logic        req_generalized_format = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_time_valid;
   logic [13:0] rsp_full_year;
   logic [3:0]  rsp_month_number;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_value;
   logic [5:0]  rsp_minute_value;
   logic [5:0]  rsp_second_value;
   int          error_count, pending_count;
   int          idle_cycles = 0;
   int          chars_sent = 0;
   bit          no_idle = 0;
   bit          start_hold = 0;
   bit          hold_done = 0;

   always #5 clock = ~clock;

   asn1_time_string_parser i_dut (.*);
   asn1_time_string_parser_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side stall, with one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (start_hold) begin
            start_hold = 0;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 38);
      end
   end

   task automatic send_char(logic [7:0] c, bit first, bit last, bit gen);
      while (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      req_first_of_string <= first;
      req_last_of_string <= last;
      req_generalized_format <= gen;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_string(logic [7:0] s[$], bit gen, bit mark_first, bit end_mark = 1);
      for (int i = 0; i < s.size(); i++)
         send_char(s[i], mark_first && i == 0, end_mark && i == s.size() - 1,
                   (i == 0) ? gen : 1'($urandom_range(1)));
   endtask

   function automatic void to_bytes(string txt, ref logic [7:0] s[$]);
      s.delete();
      for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
   endfunction

   function automatic void add_pair(ref logic [7:0] s[$], input int v);
      s.push_back(8'(CH_ZERO + v / 10));
      s.push_back(8'(CH_ZERO + v % 10));
   endfunction

   function automatic void build_time(ref logic [7:0] s[$], input bit gen);
      int y, pick;
      bit has_sec;
      s.delete();
      if (gen) begin
         pick = $urandom_range(9);
         y = (pick == 0) ? 1900 : (pick == 1) ? 9999 : (pick == 2) ? $urandom_range(1899)
             : $urandom_range(9999, 1900);
         add_pair(s, y / 100);
         add_pair(s, y % 100);
      end else begin
         add_pair(s, $urandom_range(99));
      end
      add_pair(s, $urandom_range(12, 1));
      add_pair(s, $urandom_range(31, 1));
      add_pair(s, $urandom_range(23));
      add_pair(s, $urandom_range(59));
      has_sec = $urandom_range(3) != 0;
      if (has_sec) add_pair(s, $urandom_range(59));
      if (has_sec && gen && $urandom_range(2) == 0) begin
         s.push_back(CH_DOT);
         repeat ($urandom_range(4, 1)) s.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      pick = $urandom_range(5);
      if (pick == 0 && has_sec) return;
      if (pick <= 1) begin
         s.push_back(CH_ZULU);
      end else begin
         s.push_back(pick[0] ? CH_PLUS : CH_MINUS);
         add_pair(s, $urandom_range(12));
         add_pair(s, $urandom_range(59));
      end
   endfunction

   function automatic void corrupt(ref logic [7:0] s[$]);
      int pos;
      pos = $urandom_range(s.size() - 1);
      case ($urandom_range(3))
         0: s[pos] = 8'($urandom_range(255));
         1: s.delete(pos);
         2: s.push_back(8'($urandom_range(255)));
         default: s[pos] = 8'(CH_ZERO + $urandom_range(9));
      endcase
   endfunction

   string directed_text[] = '{
      "991231235959Z", "000101000000Z", "4912312359Z", "5001010000Z",
      "19000101000000-0001", "99991231235959+1200", "00000101000000Z",
      "20240229233000+0100", "20230131000000.123456Z", "20230131000000.Z",
      "231301000000Z", "20230230120000-1259", "20230101120000", "2301011200",
      "230101120000.5Z", "230101120000+1300", "230101120000Z1", "2301011200+0000",
      "20231231235959.0000000000000000000001Z", "Q", "230101120060Z",
      "20230101000000+0059"};
   bit directed_gen[] = '{0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0, 1, 0,
                          0, 1};

   initial begin
      logic [7:0] s[$];
      bit gen;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < directed_text.size(); k++) begin
         to_bytes(directed_text[k], s);
         send_string(s, directed_gen[k], k != 2);
      end
      // a string that never ends, then one that restarts it
      to_bytes("2301", s);
      send_string(s, 0, 1, 0);
      to_bytes("230101120000Z", s);
      send_string(s, 0, 1);

      while (chars_sent < RANDOM_CHARS) begin
         if (chars_sent > 500 && chars_sent < 700) no_idle = 1;
         else no_idle = 0;
         if (chars_sent > 800 && !hold_done) begin
            start_hold = 1;
            hold_done = 1;
         end
         gen = $urandom_range(1);
         pick = $urandom_range(99);
         build_time(s, gen);
         if (pick >= 70 && pick < 85) begin
            corrupt(s);
         end else if (pick >= 85 && pick < 95) begin
            s.delete();
            repeat ($urandom_range(40, 1)) s.push_back(8'($urandom_range(255)));
         end else if (pick >= 95) begin
            repeat ($urandom_range(30, 20)) s.insert(s.size() - 1, CH_ZERO);
         end
         if (s.size() == 0) s.push_back(CH_ZULU);
         send_string(s, gen, $urandom_range(9) != 0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
